// ===== src/tracking_confidence_monitor_unit_macros.svh =====
`ifndef TRACKING_CONFIDENCE_MONITOR_UNIT_MACROS_SVH
`define TRACKING_CONFIDENCE_MONITOR_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define TCM_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define TCM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/tcm_pkg.sv =====
`timescale 1ns / 1ps
package tcm_pkg;

    localparam int COORD_BITS  = 12;
    localparam int COUNT_BITS  = 8;
    localparam int FRAME_BITS  = 12;
    localparam int TF_BITS     = 16;
    localparam int LIMIT_BITS  = 8;
    localparam int Q16_W       = 17;
    localparam int LOW_COUNT_W = 8;

    localparam int EDGE_W = COORD_BITS + 1;
    localparam int CEN_W  = COORD_BITS + 2;
    localparam int AREA_W = 2 * COORD_BITS;
    localparam int UNI_W  = AREA_W + 1;
    localparam int D2_W   = 2 * CEN_W + 1;
    localparam int F2_W   = 2 * FRAME_BITS + 1;
    localparam int F4_W   = F2_W + 2;
    localparam int DEN_W  = (UNI_W > F4_W) ? UNI_W : F4_W;
    localparam int QUO_W  = 33;
    localparam int DCNT_W = 6;
    localparam int SQ_IN_W = 32;
    localparam int ROOT_W  = 16;
    localparam int SREM_W  = ROOT_W + 1;
    localparam int SCNT_W  = 5;
    localparam int MUL_W   = (CEN_W > Q16_W) ? CEN_W : Q16_W;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int ACC_W   = 33;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD_FACTOR = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_FRAMES_LIMIT = 3'd3;

    localparam logic OP_MEASURE = 1'b0;
    localparam logic OP_RESTART = 1'b1;

    localparam logic [Q16_W-1:0] Q16_ONE  = 17'h10000;
    localparam logic [Q16_W-1:0] W_CENTER = 17'd19661;
    localparam logic [Q16_W-1:0] W_AREA   = 17'd13107;
    localparam logic [ACC_W-1:0] ROUND_HALF = 33'h8000;

    localparam logic [FRAME_BITS-1:0] RST_FRAME_WIDTH  = 12'd1920;
    localparam logic [FRAME_BITS-1:0] RST_FRAME_HEIGHT = 12'd1080;
    localparam logic [TF_BITS-1:0]    RST_THRESHOLD    = 16'd39322;
    localparam logic [LIMIT_BITS-1:0] RST_LOW_LIMIT    = 8'd3;

    typedef struct packed {
        logic                  op;
        logic [COORD_BITS-1:0] cur_x;
        logic [COORD_BITS-1:0] cur_y;
        logic [COORD_BITS-1:0] cur_w;
        logic [COORD_BITS-1:0] cur_h;
        logic [COORD_BITS-1:0] ref_x;
        logic [COORD_BITS-1:0] ref_y;
        logic [COORD_BITS-1:0] ref_w;
        logic [COORD_BITS-1:0] ref_h;
    } tcm_item_t;

    typedef struct packed {
        logic      valid;
        tcm_item_t item;
    } tcm_head_t;

    typedef struct packed {
        logic [FRAME_BITS-1:0] frame_width;
        logic [FRAME_BITS-1:0] frame_height;
        logic [TF_BITS-1:0]    threshold_factor;
        logic [LIMIT_BITS-1:0] low_frames_limit;
    } tcm_cfg_t;

endpackage

// ===== src/tcm_if.sv =====
`timescale 1ns / 1ps
interface tcm_req_if;
    import tcm_pkg::*;
    logic                  valid;
    logic                  ready;
    logic                  op;
    logic [COORD_BITS-1:0] cur_x;
    logic [COORD_BITS-1:0] cur_y;
    logic [COORD_BITS-1:0] cur_w;
    logic [COORD_BITS-1:0] cur_h;
    logic [COORD_BITS-1:0] ref_x;
    logic [COORD_BITS-1:0] ref_y;
    logic [COORD_BITS-1:0] ref_w;
    logic [COORD_BITS-1:0] ref_h;
    modport source (output valid, op, cur_x, cur_y, cur_w, cur_h,
                    ref_x, ref_y, ref_w, ref_h, input ready);
    modport sink (input valid, op, cur_x, cur_y, cur_w, cur_h,
                  ref_x, ref_y, ref_w, ref_h, output ready);
endinterface

interface tcm_rsp_if;
    import tcm_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [Q16_W-1:0]       confidence;
    logic [Q16_W-1:0]       baseline;
    logic [LOW_COUNT_W-1:0] low_count;
    logic                   too_low;
    modport source (output valid, confidence, baseline, low_count, too_low, input ready);
    modport sink (input valid, confidence, baseline, low_count, too_low, output ready);
endinterface

interface tcm_cfg_if;
    import tcm_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== src/tcm_front.sv =====
`timescale 1ns / 1ps
module tcm_front (
    input  logic              clk,
    input  logic              rst_n,
    tcm_req_if.sink           req,
    output tcm_pkg::tcm_head_t head,
    input  logic              pop
);
    import tcm_pkg::*;

    tcm_item_t  mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       push;
    tcm_item_t  in_item;

    assign req.ready = (cnt_reg != 2'd2);
    assign push      = req.valid && req.ready;

    always_comb
    begin
        in_item.op    = req.op;
        in_item.cur_x = req.cur_x;
        in_item.cur_y = req.cur_y;
        in_item.cur_w = req.cur_w;
        in_item.cur_h = req.cur_h;
        in_item.ref_x = req.ref_x;
        in_item.ref_y = req.ref_y;
        in_item.ref_w = req.ref_w;
        in_item.ref_h = req.ref_h;
    end

    assign head.valid = (cnt_reg != 2'd0);
    assign head.item  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

// ===== src/tcm_back.sv =====
`timescale 1ns / 1ps
`include "tracking_confidence_monitor_unit_macros.svh"
module tcm_back (
    input  logic              clk,
    input  logic              rst_n,
    input  tcm_pkg::tcm_head_t head,
    output logic              pop,
    input  tcm_pkg::tcm_cfg_t  cfg_regs,
    tcm_rsp_if.source         rsp
);
    import tcm_pkg::*;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_MUL  = 4'd1;
    localparam logic [3:0] ST_DSET = 4'd2;
    localparam logic [3:0] ST_DIV  = 4'd3;
    localparam logic [3:0] ST_SQRT = 4'd4;
    localparam logic [3:0] ST_WSUM = 4'd5;
    localparam logic [3:0] ST_BASE = 4'd6;
    localparam logic [3:0] ST_LMUL = 4'd7;
    localparam logic [3:0] ST_DONE = 4'd8;

    localparam logic [1:0] DSEL_IOU  = 2'd0;
    localparam logic [1:0] DSEL_CEN  = 2'd1;
    localparam logic [1:0] DSEL_AREA = 2'd2;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    logic [3:0]             state_reg;
    logic [2:0]             step_reg;
    tcm_item_t              item_reg;
    logic [COORD_BITS-1:0]  ovx_reg, ovy_reg;
    logic [CEN_W-1:0]       dx_reg, dy_reg;
    logic [AREA_W-1:0]      inter_reg, ca_reg, ra_reg;
    logic [D2_W-1:0]        d2_reg;
    logic [F2_W-1:0]        f2_reg;
    logic [1:0]             dsel_reg;
    logic [DEN_W-1:0]       rem_reg, den_reg;
    logic [QUO_W-1:0]       quo_reg;
    logic [DCNT_W-1:0]      dcnt_reg;
    logic [Q16_W-1:0]       iou_reg, center_reg, area_reg;
    logic [SQ_IN_W-1:0]     sqv_reg;
    logic [ROOT_W-1:0]      root_reg;
    logic [SREM_W-1:0]      srem_reg;
    logic [SCNT_W-1:0]      scnt_reg;
    logic [ACC_W-1:0]       acc_reg;
    logic [Q16_W-1:0]       conf_reg, bwork_reg;
    logic [PROD_W-1:0]      lprod_reg;
    logic [Q16_W-1:0]       baseline_reg;
    logic                   bset_reg;
    logic [COUNT_BITS-1:0]  lowcnt_reg;
    logic                   rsp_vld_reg;
    logic [Q16_W-1:0]       conf_out_reg, base_out_reg;
    logic [LOW_COUNT_W-1:0] cnt_out_reg;
    logic                   too_reg;

    logic                   out_free;
    logic                   rsp_set;
    logic [EDGE_W-1:0]      cx_end, cy_end, rx_end, ry_end;
    logic [EDGE_W-1:0]      lo_x, hi_x, lo_y, hi_y;
    logic [COORD_BITS-1:0]  ovx, ovy;
    logic [CEN_W-1:0]       ccx, ccy, rcx, rcy, dx, dy;
    logic [MUL_W-1:0]       mul_a, mul_b;
    logic [PROD_W-1:0]      prod;
    logic [UNI_W-1:0]       union_area;
    logic [F4_W-1:0]        f4;
    logic                   d_skip;
    logic [Q16_W-1:0]       d_val;
    logic [DEN_W-1:0]       d_num, d_den;
    logic [DCNT_W-1:0]      d_steps;
    logic [DEN_W:0]         rem2;
    logic                   dge;
    logic [DEN_W-1:0]       rem_n;
    logic [QUO_W-1:0]       quo_n;
    logic [SREM_W+1:0]      srem2, trial;
    logic                   sge;
    logic [SREM_W-1:0]      srem_n;
    logic [ROOT_W-1:0]      root_n;
    logic [ACC_W-1:0]       rnd;
    logic [Q16_W-1:0]       conf_raw, conf;
    logic                   is_low;
    logic [COUNT_BITS-1:0]  cnt_n;
    logic                   too_n;

    assign out_free = !rsp_vld_reg || rsp.ready;
    assign pop = (state_reg == ST_IDLE) && head.valid &&
                 ((head.item.op == OP_MEASURE) || out_free);
    assign rsp_set = (pop && (head.item.op == OP_RESTART)) ||
                     ((state_reg == ST_DONE) && out_free);

    always_comb
    begin
        cx_end = EDGE_W'(head.item.cur_x) + EDGE_W'(head.item.cur_w);
        cy_end = EDGE_W'(head.item.cur_y) + EDGE_W'(head.item.cur_h);
        rx_end = EDGE_W'(head.item.ref_x) + EDGE_W'(head.item.ref_w);
        ry_end = EDGE_W'(head.item.ref_y) + EDGE_W'(head.item.ref_h);
        lo_x = (head.item.cur_x > head.item.ref_x) ? EDGE_W'(head.item.cur_x)
                                                   : EDGE_W'(head.item.ref_x);
        lo_y = (head.item.cur_y > head.item.ref_y) ? EDGE_W'(head.item.cur_y)
                                                   : EDGE_W'(head.item.ref_y);
        hi_x = (cx_end < rx_end) ? cx_end : rx_end;
        hi_y = (cy_end < ry_end) ? cy_end : ry_end;
        ovx  = (hi_x > lo_x) ? COORD_BITS'(hi_x - lo_x) : '0;
        ovy  = (hi_y > lo_y) ? COORD_BITS'(hi_y - lo_y) : '0;
        ccx  = CEN_W'({head.item.cur_x, 1'b0}) + CEN_W'(head.item.cur_w);
        ccy  = CEN_W'({head.item.cur_y, 1'b0}) + CEN_W'(head.item.cur_h);
        rcx  = CEN_W'({head.item.ref_x, 1'b0}) + CEN_W'(head.item.ref_w);
        rcy  = CEN_W'({head.item.ref_y, 1'b0}) + CEN_W'(head.item.ref_h);
        dx   = (ccx > rcx) ? ccx - rcx : rcx - ccx;
        dy   = (ccy > rcy) ? ccy - rcy : rcy - ccy;
    end

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_MUL:
            begin
                case (step_reg)
                    3'd0:
                    begin
                        mul_a = MUL_W'(ovx_reg);
                        mul_b = MUL_W'(ovy_reg);
                    end
                    3'd1:
                    begin
                        mul_a = MUL_W'(item_reg.cur_w);
                        mul_b = MUL_W'(item_reg.cur_h);
                    end
                    3'd2:
                    begin
                        mul_a = MUL_W'(item_reg.ref_w);
                        mul_b = MUL_W'(item_reg.ref_h);
                    end
                    3'd3:
                    begin
                        mul_a = MUL_W'(dx_reg);
                        mul_b = MUL_W'(dx_reg);
                    end
                    3'd4:
                    begin
                        mul_a = MUL_W'(dy_reg);
                        mul_b = MUL_W'(dy_reg);
                    end
                    3'd5:
                    begin
                        mul_a = MUL_W'(cfg_regs.frame_width);
                        mul_b = MUL_W'(cfg_regs.frame_width);
                    end
                    3'd6:
                    begin
                        mul_a = MUL_W'(cfg_regs.frame_height);
                        mul_b = MUL_W'(cfg_regs.frame_height);
                    end
                    default:
                    begin
                        mul_a = '0;
                        mul_b = '0;
                    end
                endcase
            end
            ST_WSUM:
            begin
                if (step_reg == 3'd0)
                begin
                    mul_a = MUL_W'(center_reg);
                    mul_b = MUL_W'(W_CENTER);
                end
                else
                begin
                    mul_a = MUL_W'(area_reg);
                    mul_b = MUL_W'(W_AREA);
                end
            end
            ST_LMUL:
            begin
                mul_a = MUL_W'(bwork_reg);
                mul_b = MUL_W'(cfg_regs.threshold_factor);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod = mul_a * mul_b;
    end

    always_comb
    begin
        union_area = UNI_W'(ca_reg) + UNI_W'(ra_reg) - UNI_W'(inter_reg);
        f4         = {f2_reg, 2'b00};
        d_skip     = 1'b0;
        d_val      = '0;
        d_num      = '0;
        d_den      = '0;
        d_steps    = DCNT_W'(16);
        case (dsel_reg)
            DSEL_IOU:
            begin
                d_skip = (union_area == '0);
                d_val  = '0;
                d_num  = DEN_W'(inter_reg);
                d_den  = DEN_W'(union_area);
            end
            DSEL_CEN:
            begin
                d_skip  = (f4 == '0) || (d2_reg >= f4);
                d_val   = (f4 == '0) ? Q16_ONE : '0;
                d_num   = DEN_W'(d2_reg);
                d_den   = DEN_W'(f4);
                d_steps = DCNT_W'(32);
            end
            DSEL_AREA:
            begin
                d_skip = (ca_reg == '0) || (ra_reg == '0);
                d_val  = Q16_ONE;
                d_num  = (ca_reg < ra_reg) ? DEN_W'(ca_reg) : DEN_W'(ra_reg);
                d_den  = (ca_reg < ra_reg) ? DEN_W'(ra_reg) : DEN_W'(ca_reg);
            end
            default:
            begin
                d_skip = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        rem2   = {rem_reg, 1'b0};
        dge    = (rem2 >= {1'b0, den_reg});
        rem_n  = dge ? DEN_W'(rem2 - {1'b0, den_reg}) : DEN_W'(rem2);
        quo_n  = {quo_reg[QUO_W-2:0], dge};
        srem2  = {srem_reg, sqv_reg[SQ_IN_W-1 -: 2]};
        trial  = {1'b0, root_reg, 2'b01};
        sge    = (srem2 >= trial);
        srem_n = sge ? SREM_W'(srem2 - trial) : SREM_W'(srem2);
        root_n = {root_reg[ROOT_W-2:0], sge};
        rnd      = acc_reg + ROUND_HALF;
        conf_raw = rnd[ACC_W-1:16];
        conf     = (conf_raw > Q16_ONE) ? Q16_ONE : conf_raw;
        is_low = (bwork_reg != '0) &&
                 ({1'b0, conf_reg, 16'h0000} < PROD_W'(lprod_reg));
        if (is_low)
        begin
            cnt_n = (lowcnt_reg == COUNT_MAX) ? lowcnt_reg : lowcnt_reg + 1'b1;
        end
        else
        begin
            cnt_n = '0;
        end
        too_n = (bwork_reg != '0) && (32'(cnt_n) >= 32'(cfg_regs.low_frames_limit));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_vld_reg <= 1'b0;
        end
        else if (rsp_set)
        begin
            rsp_vld_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            step_reg     <= '0;
            dsel_reg     <= DSEL_IOU;
            dcnt_reg     <= '0;
            scnt_reg     <= '0;
            baseline_reg <= '0;
            bset_reg     <= 1'b0;
            lowcnt_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (pop && (head.item.op == OP_RESTART))
                    begin
                        baseline_reg <= '0;
                        bset_reg     <= 1'b0;
                        lowcnt_reg   <= '0;
                    end
                    else if (pop)
                    begin
                        step_reg  <= '0;
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL:
                begin
                    step_reg <= step_reg + 3'd1;
                    if (step_reg == 3'd6)
                    begin
                        dsel_reg  <= DSEL_IOU;
                        state_reg <= ST_DSET;
                    end
                end
                ST_DSET:
                begin
                    if (d_skip)
                    begin
                        if (dsel_reg == DSEL_AREA)
                        begin
                            step_reg  <= '0;
                            state_reg <= ST_WSUM;
                        end
                        else
                        begin
                            dsel_reg <= dsel_reg + 2'd1;
                        end
                    end
                    else
                    begin
                        dcnt_reg  <= d_steps;
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    dcnt_reg <= dcnt_reg - 1'b1;
                    if (dcnt_reg == DCNT_W'(1))
                    begin
                        case (dsel_reg)
                            DSEL_IOU:
                            begin
                                dsel_reg  <= DSEL_CEN;
                                state_reg <= ST_DSET;
                            end
                            DSEL_CEN:
                            begin
                                scnt_reg  <= SCNT_W'(ROOT_W);
                                state_reg <= ST_SQRT;
                            end
                            default:
                            begin
                                step_reg  <= '0;
                                state_reg <= ST_WSUM;
                            end
                        endcase
                    end
                end
                ST_SQRT:
                begin
                    scnt_reg <= scnt_reg - 1'b1;
                    if (scnt_reg == SCNT_W'(1))
                    begin
                        dsel_reg  <= DSEL_AREA;
                        state_reg <= ST_DSET;
                    end
                end
                ST_WSUM:
                begin
                    step_reg <= step_reg + 3'd1;
                    if (step_reg != 3'd0)
                    begin
                        state_reg <= ST_BASE;
                    end
                end
                ST_BASE:
                begin
                    state_reg <= ST_LMUL;
                end
                ST_LMUL:
                begin
                    state_reg <= ST_DONE;
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        baseline_reg <= bwork_reg;
                        bset_reg     <= 1'b1;
                        lowcnt_reg   <= cnt_n;
                        state_reg    <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                item_reg     <= head.item;
                ovx_reg      <= ovx;
                ovy_reg      <= ovy;
                dx_reg       <= dx;
                dy_reg       <= dy;
                if (pop && (head.item.op == OP_RESTART))
                begin
                    conf_out_reg <= '0;
                    base_out_reg <= '0;
                    cnt_out_reg  <= '0;
                    too_reg      <= 1'b0;
                end
            end
            ST_MUL:
            begin
                case (step_reg)
                    3'd0: inter_reg <= AREA_W'(prod);
                    3'd1: ca_reg    <= AREA_W'(prod);
                    3'd2: ra_reg    <= AREA_W'(prod);
                    3'd3: d2_reg    <= D2_W'(prod);
                    3'd4: d2_reg    <= d2_reg + D2_W'(prod);
                    3'd5: f2_reg    <= F2_W'(prod);
                    3'd6: f2_reg    <= f2_reg + F2_W'(prod);
                    default: f2_reg <= f2_reg;
                endcase
            end
            ST_DSET:
            begin
                if (d_skip)
                begin
                    case (dsel_reg)
                        DSEL_IOU: iou_reg    <= d_val;
                        DSEL_CEN: center_reg <= d_val;
                        default:  area_reg   <= d_val;
                    endcase
                end
                den_reg <= d_den;
                rem_reg <= (d_num >= d_den) ? d_num - d_den : d_num;
                quo_reg <= QUO_W'(d_num >= d_den);
            end
            ST_DIV:
            begin
                rem_reg <= rem_n;
                quo_reg <= quo_n;
                if (dcnt_reg == DCNT_W'(1))
                begin
                    case (dsel_reg)
                        DSEL_IOU: iou_reg  <= Q16_W'(quo_n);
                        DSEL_CEN: sqv_reg  <= SQ_IN_W'(quo_n);
                        default:  area_reg <= Q16_W'(quo_n);
                    endcase
                end
                root_reg <= '0;
                srem_reg <= '0;
            end
            ST_SQRT:
            begin
                srem_reg <= srem_n;
                root_reg <= root_n;
                sqv_reg  <= {sqv_reg[SQ_IN_W-3:0], 2'b00};
                if (scnt_reg == SCNT_W'(1))
                begin
                    center_reg <= Q16_ONE - Q16_W'(root_n);
                end
            end
            ST_WSUM:
            begin
                if (step_reg == 3'd0)
                begin
                    acc_reg <= ACC_W'({iou_reg, 15'h0000}) + ACC_W'(prod);
                end
                else
                begin
                    acc_reg <= acc_reg + ACC_W'(prod);
                end
            end
            ST_BASE:
            begin
                conf_reg  <= conf;
                bwork_reg <= (!bset_reg || (conf > baseline_reg)) ? conf : baseline_reg;
            end
            ST_LMUL:
            begin
                lprod_reg <= prod;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    conf_out_reg <= conf_reg;
                    base_out_reg <= bwork_reg;
                    cnt_out_reg  <= LOW_COUNT_W'(cnt_n);
                    too_reg      <= too_n;
                end
            end
            default:
            begin
                acc_reg <= acc_reg;
            end
        endcase
    end

    assign rsp.valid      = rsp_vld_reg;
    assign rsp.confidence = conf_out_reg;
    assign rsp.baseline   = base_out_reg;
    assign rsp.low_count  = cnt_out_reg;
    assign rsp.too_low    = too_reg;

    `TCM_ASSERT_IMPLY(a_too_low_base, clk, rst_n, rsp_vld_reg && too_reg, base_out_reg != '0, "too_low raised with a zero baseline")
    `TCM_ASSERT_IMPLY(a_unset_zero, clk, rst_n, !bset_reg, baseline_reg == '0, "baseline nonzero while unset")
    `TCM_ASSERT_NEXT(a_measure_sets, clk, rst_n, (state_reg == ST_DONE) && out_free, bset_reg && rsp_vld_reg, "finished measure left baseline unset")
    `TCM_ASSERT_IMPLY(a_div_rem, clk, rst_n, state_reg == ST_DIV, rem_reg < den_reg, "divider remainder out of range")

endmodule

// ===== src/tracking_confidence_monitor_unit.sv =====
`timescale 1ns / 1ps
// A measure item passes through the bit-serial divider (16 + 32 + 16 steps) and the
// 16-step square root; a restart only clears the tracking state and returns a zeroed result.
// Skipped divisions (empty union, empty box, zero frame, far centers) shorten a measure item.
// The back end takes one item at a time; the two-entry queue in front still accepts items.
// Reset (rst_n, asynchronous, active low) clears the queue, baseline, counter and output
// valid, and loads the configuration registers with their default values.
module tracking_confidence_monitor_unit (
    input logic     clk,
    input logic     rst_n,
    tcm_req_if.sink req,
    tcm_rsp_if.source rsp,
    tcm_cfg_if.sink cfg
);
    import tcm_pkg::*;

    tcm_cfg_t  cfg_reg;
    tcm_head_t head;
    logic      pop;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_width      <= RST_FRAME_WIDTH;
            cfg_reg.frame_height     <= RST_FRAME_HEIGHT;
            cfg_reg.threshold_factor <= RST_THRESHOLD;
            cfg_reg.low_frames_limit <= RST_LOW_LIMIT;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                CFG_FRAME_WIDTH:      cfg_reg.frame_width      <= FRAME_BITS'(cfg.data);
                CFG_FRAME_HEIGHT:     cfg_reg.frame_height     <= FRAME_BITS'(cfg.data);
                CFG_THRESHOLD_FACTOR: cfg_reg.threshold_factor <= TF_BITS'(cfg.data);
                CFG_LOW_FRAMES_LIMIT: cfg_reg.low_frames_limit <= LIMIT_BITS'(cfg.data);
                default:              cfg_reg <= cfg_reg;
            endcase
        end
    end

    tcm_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .head  (head),
        .pop   (pop)
    );

    tcm_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .pop      (pop),
        .cfg_regs (cfg_reg),
        .rsp      (rsp)
    );

endmodule

// ===== verif/tcm_test_if.sv =====
`timescale 1ns / 1ps
// The block's interfaces are defined with the RTL sources; this file holds the score and
// row types that the testbench uses beside them.
package tcm_test_pkg;
    import tcm_pkg::*;

    typedef struct packed {
        logic [Q16_W-1:0]       confidence;
        logic [Q16_W-1:0]       baseline;
        logic [LOW_COUNT_W-1:0] low_count;
        logic                   too_low;
    } tcm_score_t;

    typedef struct packed {
        tcm_item_t  item;
        logic       known;
        tcm_score_t score;
    } tcm_row_t;
endpackage

// ===== verif/tracking_confidence_monitor_unit_test.sv =====
`timescale 1ns / 1ps
module tracking_confidence_monitor_unit_test;
    import tcm_pkg::*;
    import tcm_test_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RANDOM_ITEMS = 600;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_INDEX = 3'd7;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    tcm_req_if req();
    tcm_rsp_if rsp();
    tcm_cfg_if cfg();

    tracking_confidence_monitor_unit DUT (
        .clk(clk),
        .rst_n(rst_n),
        .req(req.sink),
        .rsp(rsp.source),
        .cfg(cfg.sink)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    logic [11:0] fw, fh;
    logic [15:0] tfac;
    logic [7:0]  lim;
    logic [16:0] base_val;
    logic        base_set;
    logic [7:0]  low_cnt;

    tcm_score_t pending_scores[$];
    tcm_score_t pinned_scores[$];
    bit         pinned_flags[$];
    int mismatches = 0;
    int idle_cycles = 0;
    int rsp_wait = 0;
    bit timed_out = 0;

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic logic [63:0] overlap(input logic [63:0] a0, aw, b0, bw);
        logic [63:0] lo, hi;
        lo = (a0 > b0) ? a0 : b0;
        hi = ((a0 + aw) < (b0 + bw)) ? (a0 + aw) : (b0 + bw);
        return (hi > lo) ? hi - lo : 64'd0;
    endfunction

    function automatic logic [16:0] box_score(input tcm_item_t it);
        logic [63:0] ca, ra, inter, uni, iou, dx, dy, d2, f4, center, area, ratio, sum, conf;
        logic [63:0] a, b;
        ca = 64'(it.cur_w) * it.cur_h;
        ra = 64'(it.ref_w) * it.ref_h;
        inter = overlap(it.cur_x, it.cur_w, it.ref_x, it.ref_w)
              * overlap(it.cur_y, it.cur_h, it.ref_y, it.ref_h);
        uni = ca + ra - inter;
        iou = (uni == 0) ? 64'd0 : (inter << 16) / uni;
        a = 2 * 64'(it.cur_x) + it.cur_w;
        b = 2 * 64'(it.ref_x) + it.ref_w;
        dx = (a > b) ? a - b : b - a;
        a = 2 * 64'(it.cur_y) + it.cur_h;
        b = 2 * 64'(it.ref_y) + it.ref_h;
        dy = (a > b) ? a - b : b - a;
        d2 = dx * dx + dy * dy;
        f4 = 4 * (64'(fw) * fw + 64'(fh) * fh);
        if (f4 == 0)
            center = 65536;
        else if (d2 >= f4)
            center = 0;
        else
        begin
            ratio = int_sqrt((d2 << 32) / f4);
            if (ratio > 65536)
                ratio = 65536;
            center = 65536 - ratio;
        end
        if (ca == 0 || ra == 0)
            area = 65536;
        else if (ca < ra)
            area = (ca << 16) / ra;
        else
            area = (ra << 16) / ca;
        sum = iou * 32768 + center * 19661 + area * 13107;
        conf = (sum + 32768) >> 16;
        if (conf > 65536)
            conf = 65536;
        return conf[16:0];
    endfunction

    function automatic tcm_score_t track_step(input tcm_item_t it);
        tcm_score_t s;
        logic [16:0] c;
        s = '0;
        if (it.op == OP_RESTART)
        begin
            base_val = 0;
            base_set = 0;
            low_cnt = 0;
            return s;
        end
        c = box_score(it);
        if (!base_set || c > base_val)
        begin
            base_val = c;
            base_set = 1;
        end
        if (base_val > 0 && (64'(c) << 16) < 64'(base_val) * tfac)
        begin
            if (low_cnt != 8'hFF)
                low_cnt = low_cnt + 8'd1;
        end
        else
            low_cnt = 0;
        s.confidence = c;
        s.baseline = base_val;
        s.low_count = low_cnt;
        s.too_low = (base_val > 0) && (low_cnt >= lim);
        return s;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        int draw;
        if (!rst_n)
        begin
            rsp.ready <= 1'b0;
            rsp_wait <= 0;
        end
        else if (rsp.valid && rsp.ready)
        begin
            draw = $urandom_range(0, 15);
            rsp_wait <= draw;
            rsp.ready <= (draw == 0);
        end
        else if (!rsp.ready)
        begin
            if (rsp_wait <= 1)
                rsp.ready <= 1'b1;
            rsp_wait <= (rsp_wait > 0) ? rsp_wait - 1 : 0;
        end
    end

    always @(posedge clk)
    begin
        tcm_score_t exp_s;
        tcm_score_t got;
        if (rst_n)
        begin
            if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (cfg.valid && cfg.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (rsp.valid && rsp.ready)
            begin
                got.confidence = rsp.confidence;
                got.baseline = rsp.baseline;
                got.low_count = rsp.low_count;
                got.too_low = rsp.too_low;
                if (pending_scores.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result %h", got);
                end
                else
                begin
                    exp_s = pending_scores.pop_front();
                    if (pinned_flags.pop_front())
                    begin
                        if (pinned_scores.pop_front() != exp_s)
                        begin
                            mismatches++;
                            if (mismatches <= 10)
                                $display("table value disagrees with prediction %h", exp_s);
                        end
                    end
                    if (got != exp_s)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected conf %0d base %0d cnt %0d low %0d, got conf %0d base %0d cnt %0d low %0d",
                                exp_s.confidence, exp_s.baseline, exp_s.low_count, exp_s.too_low,
                                got.confidence, got.baseline, got.low_count, got.too_low);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (idle_cycles >= WATCHDOG_LIMIT && !timed_out)
        begin
            timed_out = 1;
            $display("simulation failed");
            $finish;
        end
    end

    // The caller drops valid after the last write of a burst.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        cfg.index <= idx;
        cfg.data <= val;
        cfg.valid <= 1'b1;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        case (idx)
            CFG_FRAME_WIDTH: fw = val[11:0];
            CFG_FRAME_HEIGHT: fh = val[11:0];
            CFG_THRESHOLD_FACTOR: tfac = val;
            CFG_LOW_FRAMES_LIMIT: lim = val[7:0];
            default: ;
        endcase
    endtask

    // Valid stays high after an accepted item; drain() drops it, and the next call drops it only before a random gap.
    task automatic send_item(input tcm_item_t it, input bit pinned, input tcm_score_t pin);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.op <= it.op;
        req.cur_x <= it.cur_x;
        req.cur_y <= it.cur_y;
        req.cur_w <= it.cur_w;
        req.cur_h <= it.cur_h;
        req.ref_x <= it.ref_x;
        req.ref_y <= it.ref_y;
        req.ref_w <= it.ref_w;
        req.ref_h <= it.ref_h;
        req.valid <= 1'b1;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        pending_scores.push_back(track_step(it));
        pinned_flags.push_back(pinned);
        if (pinned)
            pinned_scores.push_back(pin);
    endtask

    task automatic drain();
        req.valid <= 1'b0;
        while (pending_scores.size() > 0)
            @(posedge clk);
        repeat (120) @(posedge clk);
    endtask

    function automatic tcm_item_t box_pair(input logic op,
        input logic [11:0] cx, cy, cw, ch, rx, ry, rw, rh);
        tcm_item_t it;
        it = {op, cx, cy, cw, ch, rx, ry, rw, rh};
        return it;
    endfunction

    function automatic tcm_item_t random_item(input int mode);
        tcm_item_t it;
        it = tcm_item_t'(97'({$urandom, $urandom, $urandom, $urandom}));
        it.op = ($urandom_range(0, 19) == 0) ? OP_RESTART : OP_MEASURE;
        if (mode == 0)
        begin
            it.ref_x = 12'($urandom_range(0, 1500));
            it.ref_y = 12'($urandom_range(0, 900));
            it.ref_w = 12'($urandom_range(1, 300));
            it.ref_h = 12'($urandom_range(1, 300));
            it.cur_x = it.ref_x + 12'($urandom_range(0, 40));
            it.cur_y = it.ref_y + 12'($urandom_range(0, 40));
            it.cur_w = it.ref_w + 12'($urandom_range(0, 40));
            it.cur_h = it.ref_h + 12'($urandom_range(0, 40));
        end
        else if (mode == 1)
        begin
            it.cur_w = 12'($urandom_range(0, 3));
            it.ref_h = 12'($urandom_range(0, 3));
        end
        return it;
    endfunction

    tcm_row_t directed_rows[$];

    initial
    begin
        tcm_score_t none;
        tcm_score_t z;
        tcm_item_t it;
        int phase;
        none = '0;
        z = '0;
        req.valid = 1'b0;
        req.op = OP_MEASURE;
        {req.cur_x, req.cur_y, req.cur_w, req.cur_h} = '0;
        {req.ref_x, req.ref_y, req.ref_w, req.ref_h} = '0;
        cfg.valid = 1'b0;
        cfg.index = '0;
        cfg.data = '0;
        fw = 1920;
        fh = 1080;
        tfac = 39322;
        lim = 3;
        base_val = 0;
        base_set = 0;
        low_cnt = 0;

        // Identical boxes score one; restart clears everything.
        directed_rows.push_back({box_pair(OP_MEASURE, 100, 100, 50, 50, 100, 100, 50, 50),
                                 1'b1, tcm_score_t'({17'h10000, 17'h10000, 8'd0, 1'b0})});
        directed_rows.push_back({box_pair(OP_RESTART, 4095, 4095, 4095, 4095, 4095, 4095, 4095, 4095),
                                 1'b1, z});
        // First measure after the restart, with zero-size boxes, sets the baseline.
        directed_rows.push_back({box_pair(OP_MEASURE, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, none});
        directed_rows.push_back({box_pair(OP_MEASURE, 0, 0, 4095, 4095, 4095, 4095, 4095, 4095),
                                 1'b0, none});
        directed_rows.push_back({box_pair(OP_MEASURE, 0, 0, 1, 1, 4095, 4095, 0, 0), 1'b0, none});
        directed_rows.push_back({box_pair(OP_MEASURE, 10, 10, 20, 20, 10, 10, 20, 20), 1'b0, none});
        // A string of poor readings drives the counter to the limit.
        for (int k = 0; k < 5; k++)
            directed_rows.push_back({box_pair(OP_MEASURE, 0, 0, 10, 10, 3000, 3000, 500, 20),
                                     1'b0, none});
        directed_rows.push_back({box_pair(OP_MEASURE, 4095, 4095, 4095, 4095, 0, 0, 4095, 4095),
                                 1'b0, none});
        directed_rows.push_back({box_pair(OP_RESTART, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, z});

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_item(directed_rows[i].item, directed_rows[i].known, directed_rows[i].score);
        drain();

        for (phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0:
                begin
                    write_reg(CFG_FRAME_WIDTH, 16'hFFFF);
                    write_reg(CFG_FRAME_HEIGHT, 16'd4095);
                    write_reg(CFG_THRESHOLD_FACTOR, 16'd65535);
                    write_reg(CFG_LOW_FRAMES_LIMIT, 16'd1);
                end
                1:
                begin
                    write_reg(CFG_FRAME_WIDTH, 16'd0);
                    write_reg(CFG_FRAME_HEIGHT, 16'd0);
                    write_reg(CFG_THRESHOLD_FACTOR, 16'd0);
                    write_reg(CFG_LOW_FRAMES_LIMIT, 16'd0);
                    write_reg(CFG_UNUSED_INDEX, 16'h1234);
                end
                2:
                begin
                    write_reg(CFG_FRAME_WIDTH, 16'd1);
                    write_reg(CFG_FRAME_HEIGHT, 16'd1);
                    write_reg(CFG_THRESHOLD_FACTOR, 16'd60000);
                    write_reg(CFG_LOW_FRAMES_LIMIT, 16'd255);
                end
                3:
                begin
                    write_reg(CFG_FRAME_WIDTH, 16'd1920);
                    write_reg(CFG_FRAME_HEIGHT, 16'd1080);
                    write_reg(CFG_THRESHOLD_FACTOR, 16'd39322);
                    write_reg(CFG_LOW_FRAMES_LIMIT, 16'd3);
                end
                default:
                begin
                    write_reg(CFG_FRAME_WIDTH, 16'($urandom_range(0, 65535)));
                    write_reg(CFG_FRAME_HEIGHT, 16'($urandom_range(0, 65535)));
                    write_reg(CFG_THRESHOLD_FACTOR, 16'($urandom_range(0, 65535)));
                    write_reg(CFG_LOW_FRAMES_LIMIT, 16'($urandom_range(0, 255)));
                end
            endcase
            cfg.valid <= 1'b0;
            for (int n = 0; n < RANDOM_ITEMS / 6; n++)
            begin
                it = random_item(($urandom_range(0, 9) < 7) ? 0 : $urandom_range(1, 2));
                send_item(it, 1'b0, none);
            end
            drain();
        end

        if (mismatches == 0 && pending_scores.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
